// ----- src/lru_pkg.sv -----
package lru_pkg;

  // fixed field widths
  localparam int DATA_W = 32;
  localparam int OCC_W  = 5;
  localparam int CAP_W  = 5;

  // capacity register reset value
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // widths of the channel words
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 2;
  localparam int IN_TDATA_W  = 64;

  // summary of one lookup, passed from the match array to the top level
  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] hit_value;
    logic [DATA_W-1:0] victim_key;
  } lookup_t;

endpackage

// ----- src/lru_match.sv -----
module lru_match #(
  parameter int ENTRIES = 16,
  parameter int AW      = $clog2(ENTRIES),
  parameter int FW      = $clog2(ENTRIES + 1)
) (
  input  logic [lru_pkg::DATA_W-1:0] key,
  input  logic [ENTRIES-1:0]         entry_valid,
  input  logic [lru_pkg::DATA_W-1:0] entry_key   [ENTRIES],
  input  logic [lru_pkg::DATA_W-1:0] entry_value [ENTRIES],
  input  logic [AW-1:0]              entry_age   [ENTRIES],
  input  logic [FW-1:0]              fill,
  output logic [ENTRIES-1:0]         match,
  output logic [ENTRIES-1:0]         victim,
  output logic [ENTRIES-1:0]         first_free,
  output logic [AW-1:0]              hit_age,
  output lru_pkg::lookup_t           lookup
);

  logic [FW-1:0]      oldest_age;
  logic [ENTRIES-1:0] free;

  // ranks of valid entries are exactly 0 .. fill-1, so the oldest has fill-1
  assign oldest_age = fill - FW'(1);
  assign free       = ~entry_valid;
  assign first_free = free & (~free + ENTRIES'(1));

  // parallel key compare and one-hot selects
  always_comb begin
    lookup = '0;
    hit_age = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = entry_valid[i] && (entry_key[i] == key);
      victim[i] = entry_valid[i] && (entry_age[i] == oldest_age[AW-1:0]);
      if (match[i]) begin
        lookup.hit_value = lookup.hit_value | entry_value[i];
        hit_age          = hit_age | entry_age[i];
      end
      if (victim[i]) begin
        lookup.victim_key = lookup.victim_key | entry_key[i];
      end
    end
    lookup.hit = |match;
  end

endmodule

// ----- src/lru_cache_lookup_insert.sv -----
// Channel | Dir | Bits | Fields (low bit first)
// in_     | in  | 64   | tdata: key[31:0], value[63:32]
// out_    | out | 72+2 | tdata: data_out[31:0], evicted_key[63:32], occupancy[68:64];
//         |     |      | tuser: hit[0], evicted[1]
// cfg_    | in  | 5    | capacity, written when cfg_wr_en is high
//
// One word per cycle sustained while the output is not stalled; the result is
// registered after the input register. The rate is set by the parallel key compare
// and rank update over all entries between the input and result registers.
// Synchronous active-low reset empties the cache and sets capacity to 16.
// A stalled result holds in the output register; the input register keeps
// accepting while the result slot is free or being drained.
module lru_cache_lookup_insert #(
  parameter int ENTRIES = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // key[31:0], value[63:32]
  input  logic [lru_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // data_out[31:0], evicted_key[63:32], occupancy[68:64], zero fill above
  output logic [lru_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // hit[0], evicted[1]
  output logic [lru_pkg::OUT_TUSER_W-1:0]  out_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_wr_en,
  input  logic [lru_pkg::CAP_W-1:0]        cfg_wr_data
);

  localparam int AW    = $clog2(ENTRIES);
  localparam int FW    = $clog2(ENTRIES + 1);
  localparam int CMP_W = (FW > lru_pkg::CAP_W) ? FW : lru_pkg::CAP_W;
  localparam int DW    = lru_pkg::DATA_W;

  // input register
  logic          in_valid_r;
  logic [DW-1:0] in_key_r;
  logic [DW-1:0] in_value_r;

  // cache state
  logic [ENTRIES-1:0] entry_valid_r, entry_valid_nxt;
  logic [DW-1:0]      entry_key_r   [ENTRIES];
  logic [DW-1:0]      entry_value_r [ENTRIES];
  logic [AW-1:0]      entry_age_r   [ENTRIES];
  logic [AW-1:0]      entry_age_nxt [ENTRIES];
  logic [FW-1:0]      fill_r, fill_nxt;
  logic [lru_pkg::CAP_W-1:0] cap_r;

  // result register
  logic                    out_valid_r;
  logic                    out_hit_r, out_hit_nxt;
  logic                    out_evicted_r, out_evicted_nxt;
  logic [DW-1:0]           out_data_r, out_data_nxt;
  logic [DW-1:0]           out_evkey_r, out_evkey_nxt;
  logic [lru_pkg::OCC_W-1:0] out_occ_r, out_occ_nxt;

  logic               advance;
  logic [ENTRIES-1:0] match, victim, first_free, slot;
  logic [AW-1:0]      hit_age;
  lru_pkg::lookup_t   lookup;
  logic               insert;
  logic [CMP_W-1:0]   fill_ext, cap_ext;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  lru_match #(
    .ENTRIES (ENTRIES),
    .AW      (AW),
    .FW      (FW)
  ) u_match (
    .key         (in_key_r),
    .entry_valid (entry_valid_r),
    .entry_key   (entry_key_r),
    .entry_value (entry_value_r),
    .entry_age   (entry_age_r),
    .fill        (fill_r),
    .match       (match),
    .victim      (victim),
    .first_free  (first_free),
    .hit_age     (hit_age),
    .lookup      (lookup)
  );

  // room for a new entry: below both the capacity (zero reads as one) and the array size
  always_comb begin
    fill_ext = CMP_W'(fill_r);
    cap_ext  = (cap_r == '0) ? CMP_W'(1) : CMP_W'(cap_r);
    insert   = (fill_ext < cap_ext) && (fill_ext < CMP_W'(ENTRIES));
    slot     = insert ? first_free : victim;
  end

  // next ranks, valid bits, fill count and result word
  always_comb begin
    entry_valid_nxt = entry_valid_r;
    fill_nxt        = fill_r;
    for (int i = 0; i < ENTRIES; i++) begin
      entry_age_nxt[i] = entry_age_r[i];
    end
    if (lookup.hit) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (match[i]) begin
          entry_age_nxt[i] = '0;
        end else if (entry_valid_r[i] && (entry_age_r[i] < hit_age)) begin
          entry_age_nxt[i] = entry_age_r[i] + AW'(1);
        end
      end
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot[i]) begin
          entry_age_nxt[i]   = '0;
          entry_valid_nxt[i] = 1'b1;
        end else if (entry_valid_r[i]) begin
          entry_age_nxt[i] = entry_age_r[i] + AW'(1);
        end
      end
      if (insert) begin
        fill_nxt = fill_r + FW'(1);
      end
    end
    out_hit_nxt     = lookup.hit;
    out_data_nxt    = lookup.hit ? lookup.hit_value : in_value_r;
    out_evicted_nxt = !lookup.hit && !insert;
    out_evkey_nxt   = out_evicted_nxt ? lookup.victim_key : '0;
    out_occ_nxt     = lru_pkg::OCC_W'(fill_nxt);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      entry_valid_r <= '0;
      fill_r        <= '0;
      cap_r         <= lru_pkg::CAP_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
        entry_age_r[i] <= '0;
      end
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (advance) begin
        entry_valid_r <= entry_valid_nxt;
        fill_r        <= fill_nxt;
        for (int i = 0; i < ENTRIES; i++) begin
          entry_age_r[i] <= entry_age_nxt[i];
        end
      end
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_key_r   <= in_tdata[DW-1:0];
      in_value_r <= in_tdata[2*DW-1:DW];
    end
    if (advance) begin
      out_hit_r     <= out_hit_nxt;
      out_data_r    <= out_data_nxt;
      out_evicted_r <= out_evicted_nxt;
      out_evkey_r   <= out_evkey_nxt;
      out_occ_r     <= out_occ_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        if (!lookup.hit && slot[i]) begin
          entry_key_r[i]   <= in_key_r;
          entry_value_r[i] <= in_value_r;
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_evicted_r, out_hit_r};
  assign out_tdata  = {{(lru_pkg::OUT_TDATA_W - 2*DW - lru_pkg::OCC_W){1'b0}},
                       out_occ_r, out_evkey_r, out_data_r};

  // valid bits and fill count agree
  a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(entry_valid_r) == 32'(fill_r))
    else $error("fill count differs from number of valid entries");

  // keys are unique among valid entries
  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r |-> $onehot0(match))
    else $error("key matched more than one entry");

  // a miss on a nonempty full cache always finds exactly one oldest entry
  a_victim_one: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !lookup.hit && !insert) |-> $onehot(victim))
    else $error("eviction without a single oldest entry");

  // eviction only on a miss
  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_evicted_r))
    else $error("hit reported with eviction");

endmodule
